// ===== hdl/bounded_deque_with_index_read_top_assert.svh =====
// assertion macros for the deque block
// used by bounded_deque_with_index_read_top; expects clk and rst_n in scope
`ifndef BOUNDED_DEQUE_WITH_INDEX_READ_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_INDEX_READ_TOP_ASSERT_SVH

// condition holds in the same cycle
`define DQ_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("deque check failed (same cycle)");

// condition holds in the next cycle
`define DQ_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("deque check failed (next cycle)");

`endif

// ===== hdl/dq_pkg.sv =====
// shared types and constants for the bounded deque
// no dependencies
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 64;
  localparam int CMD_W          = 3;
  localparam int POS_W          = 5;
  localparam int CNT_W          = 5;
  localparam int ST_W           = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ       = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // what every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_SHIFT_UP   = 2'd1,
    CELL_SHIFT_DOWN = 2'd2,
    CELL_WRITE      = 2'd3
  } cell_op_t;

endpackage

// ===== hdl/dq_in_if.sv =====
// request channel of the deque: valid/ready plus command, word and position
// depends on dq_pkg
interface dq_in_if
  import dq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [DATA_WIDTH-1:0]   data_in;
  logic signed [POS_W-1:0] position;

  modport source (output valid, command, data_in, position, input ready);
  modport sink   (input valid, command, data_in, position, output ready);
endinterface

// ===== hdl/dq_out_if.sv =====
// result channel of the deque: valid/ready plus word, status and count
// depends on dq_pkg
interface dq_out_if
  import dq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data_out;
  logic [ST_W-1:0]       status;
  logic [CNT_W-1:0]      count;

  modport source (output valid, data_out, status, count, input ready);
  modport sink   (input valid, data_out, status, count, output ready);
endinterface

// ===== hdl/dq_cell.sv =====
// one entry of the deque chain: holds a word, takes it from a neighbor or the input
// depends on dq_pkg
module dq_cell
  import dq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic                  wr_sel,
  input  logic [DATA_WIDTH-1:0] din,
  input  logic [DATA_WIDTH-1:0] lower_q,
  input  logic [DATA_WIDTH-1:0] upper_q,
  output logic [DATA_WIDTH-1:0] q
);

  logic [DATA_WIDTH-1:0] q_r;
  logic [DATA_WIDTH-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    unique case (op)
      CELL_HOLD:       q_nxt = q_r;
      CELL_SHIFT_UP:   q_nxt = lower_q;
      CELL_SHIFT_DOWN: q_nxt = upper_q;
      CELL_WRITE: begin
        if (wr_sel) begin
          q_nxt = din;
        end
      end
      default:         q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ===== hdl/dq_chain.sv =====
// row of deque cells, entry 0 is the front; shifts, indexed write and indexed read
// depends on dq_pkg and dq_cell
module dq_chain
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int IW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [DATA_WIDTH-1:0] din,
  input  logic [IW-1:0]         wr_idx,
  input  logic [IW-1:0]         rd_idx,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_q;
    logic [DATA_WIDTH-1:0] upper_q;

    // front cell takes the pushed word, last cell has no upper neighbor
    if (i == 0) begin : g_front
      assign lower_q = din;
    end else begin : g_mid_lo
      assign lower_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_back
      assign upper_q = cell_q[i];
    end else begin : g_mid_hi
      assign upper_q = cell_q[i+1];
    end

    dq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk    (clk),
      .op     (op),
      .wr_sel (wr_idx == IW'(i)),
      .din    (din),
      .lower_q(lower_q),
      .upper_q(upper_q),
      .q      (cell_q[i])
    );
  end

  // each cell drives its word only when selected
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_idx == IW'(i)) begin
        rd_data = rd_data | cell_q[i];
      end
    end
  end

endmodule

// ===== hdl/bounded_deque_with_index_read_top.sv =====
// bounded deque top level: request decode, occupancy count and result register
// depends on dq_pkg, dq_in_if, dq_out_if, dq_chain and the assertion macro header
//
// usage:
//   in_if  carries one request per item: command (push front/back, pop front/back,
//          read at a signed position, clear), a data word for pushes and a position
//          for reads; a negative position counts from the back, -1 is the last entry.
//   out_if returns exactly one item per request: the popped or read word (zero unless
//          status is ok), a status code and the entry count after the request.
//   the result is registered: the result of a request accepted at one edge is valid
//   after that edge. throughput is one item per cycle while the receiver takes each
//   result; the cell row shifts, writes or is read once per request.
//   the result register parts the two sides: in_if.ready is high while the result
//   register is empty or being taken, so a stalled receiver holds one result and
//   stops further requests until it is taken.
//   reset (synchronous, active low) empties the deque and the result register;
//   the entries themselves are not cleared and no clearing pass is needed, since
//   an entry is only read after it was written.
module bounded_deque_with_index_read_top
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  dq_in_if.sink   in_if,
  dq_out_if.source out_if
);

  `include "bounded_deque_with_index_read_top_assert.svh"

  localparam int IW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int CW = (OW > POS_W) ? OW : POS_W;

  logic [OW-1:0]         occ_r;
  logic [OW-1:0]         occ_nxt;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic [ST_W-1:0]       out_status_r;
  logic [CNT_W-1:0]      out_count_r;

  logic                  in_fire;
  cmd_t                  cmd;
  cell_op_t              op_c;
  cell_op_t              cell_op;
  logic [ST_W-1:0]       st_c;
  logic                  use_rd;
  logic [CW-1:0]         rd_idx_cw;
  logic [CW-1:0]         occ_cw;
  logic [CW-1:0]         pos_cw;
  logic [CW-1:0]         mag_cw;
  logic [POS_W-1:0]      mag;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] data_c;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;
  assign cmd         = cmd_t'(in_if.command);

  assign occ_cw = CW'(occ_r);
  assign full   = (occ_cw == CW'(DEPTH));
  assign empty  = (occ_r == '0);
  // position bits taken as an unsigned offset, and the magnitude of a negative one
  assign pos_cw = CW'(in_if.position[POS_W-2:0]);
  assign mag    = POS_W'(~in_if.position + 1'b1);
  assign mag_cw = CW'(mag);

  always_comb begin
    op_c      = CELL_HOLD;
    st_c      = ST_OK;
    use_rd    = 1'b0;
    rd_idx_cw = '0;
    occ_nxt   = occ_r;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          st_c = ST_FULL;
        end else begin
          op_c    = CELL_SHIFT_UP;
          occ_nxt = occ_r + OW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          st_c = ST_FULL;
        end else begin
          op_c    = CELL_WRITE;
          occ_nxt = occ_r + OW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          st_c = ST_EMPTY;
        end else begin
          op_c    = CELL_SHIFT_DOWN;
          use_rd  = 1'b1;
          occ_nxt = occ_r - OW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          st_c = ST_EMPTY;
        end else begin
          use_rd    = 1'b1;
          rd_idx_cw = occ_cw - CW'(1);
          occ_nxt   = occ_r - OW'(1);
        end
      end
      CMD_READ: begin
        if (empty) begin
          st_c = ST_EMPTY;
        end else if (!in_if.position[POS_W-1]) begin
          if (pos_cw < occ_cw) begin
            use_rd    = 1'b1;
            rd_idx_cw = pos_cw;
          end else begin
            st_c = ST_RANGE;
          end
        end else begin
          if (mag_cw <= occ_cw) begin
            use_rd    = 1'b1;
            rd_idx_cw = occ_cw - mag_cw;
          end else begin
            st_c = ST_RANGE;
          end
        end
      end
      CMD_CLEAR: begin
        occ_nxt = '0;
      end
      default: begin
        occ_nxt = occ_r;
      end
    endcase
  end

  assign cell_op = in_fire ? op_c : CELL_HOLD;

  dq_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_chain (
    .clk    (clk),
    .op     (cell_op),
    .din    (in_if.data_in),
    .wr_idx (occ_r[IW-1:0]),
    .rd_idx (rd_idx_cw[IW-1:0]),
    .rd_data(rd_data)
  );

  assign data_c = use_rd ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r   <= data_c;
      out_status_r <= st_c;
      out_count_r  <= CNT_W'(occ_nxt);
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.data_out = out_data_r;
  assign out_if.status   = out_status_r;
  assign out_if.count    = out_count_r;

  `DQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_cw <= CW'(DEPTH))
  `DQ_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_r)
  `DQ_ASSERT_NOW(a_err_data_zero, out_valid_r && out_status_r != ST_OK, out_data_r == '0)
  `DQ_ASSERT_NOW(a_count_tracks, out_valid_r, out_count_r == CNT_W'(occ_r))
  `DQ_ASSERT_NEXT(a_full_push_keeps, in_fire && full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK), occ_r == $past(occ_r))

endmodule
